// ===== hw/rtl/qpsa_pkg.sv =====
package qpsa_pkg;

  localparam int POOL_SLOTS_DEFAULT = 64;

  localparam int LINK_W     = 7;
  localparam int CAT_W      = 4;
  localparam int CNT_W      = 7;
  localparam int LIMIT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int TYPE_W     = 8;
  localparam int SLOT_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int ID_W       = 6;
  localparam int ROLE_W     = 4;
  localparam int TOTAL_W    = 6;

  localparam logic [LINK_W-1:0] LINK_END = 7'd127;
  localparam logic [CNT_W-1:0]  CNT_MAX  = 7'd127;

  localparam logic [LIMIT_W-1:0] ENEMY_LIMIT_RST      = 7'd12;
  localparam logic [LIMIT_W-1:0] PROJECTILE_LIMIT_RST = 7'd16;
  localparam logic [LIMIT_W-1:0] PICKUP_LIMIT_RST     = 7'd16;
  localparam logic [LIMIT_W-1:0] EFFECT_LIMIT_RST     = 7'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_ENEMY_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROJECTILE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PICKUP_LIMIT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_LIMIT     = 2'd3;

  localparam logic [CAT_W-1:0] CAT_FRIEND     = 4'd1;
  localparam logic [CAT_W-1:0] CAT_ENEMY      = 4'd2;
  localparam logic [CAT_W-1:0] CAT_PROJECTILE = 4'd3;
  localparam logic [CAT_W-1:0] CAT_PICKUP     = 4'd4;
  localparam logic [CAT_W-1:0] CAT_EFFECT     = 4'd5;

  localparam logic MODE_SPAWN = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [ROLE_W-1:0] FLAG_SOLID    = 4'b0001;
  localparam logic [ROLE_W-1:0] FLAG_FRIENDLY = 4'b0010;
  localparam logic [ROLE_W-1:0] FLAG_ENEMY    = 4'b0100;
  localparam logic [ROLE_W-1:0] FLAG_PICKUP   = 4'b1000;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_QUOTA_FULL = 3'd1,
    ST_POOL_EMPTY = 3'd2,
    ST_BAD_SLOT   = 3'd3,
    ST_NOT_LIVE   = 3'd4
  } status_t;

  // one entry of the slot memory: free-list link plus live state
  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic              live;
    logic [CAT_W-1:0]  cat;
  } slot_entry_t;

  // counter update from the sequencer to the quota block
  typedef struct packed {
    logic             inc;
    logic             dec;
    logic [CAT_W-1:0] cat;
  } cnt_upd_t;

  function automatic logic [ROLE_W-1:0] role_of(input logic [CAT_W-1:0] cat);
    logic [ROLE_W-1:0] r;
    case (cat)
      CAT_FRIEND:     r = FLAG_SOLID | FLAG_FRIENDLY;
      CAT_ENEMY:      r = FLAG_SOLID | FLAG_ENEMY;
      CAT_PROJECTILE: r = FLAG_SOLID;
      CAT_PICKUP:     r = FLAG_PICKUP;
      default:        r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/qpsa_slot_mem.sv =====
module qpsa_slot_mem #(
  parameter int POOL_SLOTS = qpsa_pkg::POOL_SLOTS_DEFAULT,
  parameter int AW         = $clog2(POOL_SLOTS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output qpsa_pkg::slot_entry_t  rd_data,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  qpsa_pkg::slot_entry_t  wr_data
);

  qpsa_pkg::slot_entry_t mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] touched_r;

  qpsa_pkg::slot_entry_t rd_raw_r;
  logic                  rd_hit_r;
  logic [AW-1:0]         rd_addr_r;

  qpsa_pkg::slot_entry_t rst_entry;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw_r  <= mem[rd_addr];
      rd_hit_r  <= touched_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // an entry never written reads as its power-on value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touched_r <= '0;
    end else if (wr_en) begin
      touched_r[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    rst_entry      = '0;
    rst_entry.link = '0;
    if (rd_addr_r != '0) begin
      if (rd_addr_r == AW'(POOL_SLOTS - 1)) begin
        rst_entry.link = qpsa_pkg::LINK_END;
      end else begin
        rst_entry.link = qpsa_pkg::LINK_W'(rd_addr_r) + qpsa_pkg::LINK_W'(1);
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_raw_r : rst_entry;

endmodule

// ===== hw/rtl/qpsa_quota.sv =====
module qpsa_quota (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [qpsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qpsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [qpsa_pkg::CAT_W-1:0]          chk_cat,
  output logic                                quota_full,
  input  qpsa_pkg::cnt_upd_t                  upd,
  output logic [qpsa_pkg::CNT_W-1:0]          live_nxt
);

  logic [qpsa_pkg::LIMIT_W-1:0] enemy_limit_r, projectile_limit_r;
  logic [qpsa_pkg::LIMIT_W-1:0] pickup_limit_r, effect_limit_r;

  logic [qpsa_pkg::CNT_W-1:0] live_r, enemy_r, projectile_r, pickup_r, effect_r;
  logic [qpsa_pkg::CNT_W-1:0] enemy_nxt, projectile_nxt, pickup_nxt, effect_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enemy_limit_r      <= qpsa_pkg::ENEMY_LIMIT_RST;
      projectile_limit_r <= qpsa_pkg::PROJECTILE_LIMIT_RST;
      pickup_limit_r     <= qpsa_pkg::PICKUP_LIMIT_RST;
      effect_limit_r     <= qpsa_pkg::EFFECT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        qpsa_pkg::CFG_ENEMY_LIMIT:      enemy_limit_r      <= cfg_data;
        qpsa_pkg::CFG_PROJECTILE_LIMIT: projectile_limit_r <= cfg_data;
        qpsa_pkg::CFG_PICKUP_LIMIT:     pickup_limit_r     <= cfg_data;
        qpsa_pkg::CFG_EFFECT_LIMIT:     effect_limit_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (chk_cat)
      qpsa_pkg::CAT_ENEMY:      quota_full = !(enemy_r < enemy_limit_r);
      qpsa_pkg::CAT_PROJECTILE: quota_full = !(projectile_r < projectile_limit_r);
      qpsa_pkg::CAT_PICKUP:     quota_full = !(pickup_r < pickup_limit_r);
      qpsa_pkg::CAT_EFFECT:     quota_full = !(effect_r < effect_limit_r);
      default:                  quota_full = 1'b0;
    endcase
  end

  // saturate at the top on a spawn and at zero on a free
  always_comb begin
    live_nxt       = live_r;
    enemy_nxt      = enemy_r;
    projectile_nxt = projectile_r;
    pickup_nxt     = pickup_r;
    effect_nxt     = effect_r;
    if (upd.inc) begin
      if (live_r != qpsa_pkg::CNT_MAX) live_nxt = live_r + 7'd1;
      case (upd.cat)
        qpsa_pkg::CAT_ENEMY:
          if (enemy_r != qpsa_pkg::CNT_MAX) enemy_nxt = enemy_r + 7'd1;
        qpsa_pkg::CAT_PROJECTILE:
          if (projectile_r != qpsa_pkg::CNT_MAX) projectile_nxt = projectile_r + 7'd1;
        qpsa_pkg::CAT_PICKUP:
          if (pickup_r != qpsa_pkg::CNT_MAX) pickup_nxt = pickup_r + 7'd1;
        qpsa_pkg::CAT_EFFECT:
          if (effect_r != qpsa_pkg::CNT_MAX) effect_nxt = effect_r + 7'd1;
        default: ;
      endcase
    end else if (upd.dec) begin
      if (live_r != '0) live_nxt = live_r - 7'd1;
      case (upd.cat)
        qpsa_pkg::CAT_ENEMY:      if (enemy_r != '0) enemy_nxt = enemy_r - 7'd1;
        qpsa_pkg::CAT_PROJECTILE: if (projectile_r != '0) projectile_nxt = projectile_r - 7'd1;
        qpsa_pkg::CAT_PICKUP:     if (pickup_r != '0) pickup_nxt = pickup_r - 7'd1;
        qpsa_pkg::CAT_EFFECT:     if (effect_r != '0) effect_nxt = effect_r - 7'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r       <= '0;
      enemy_r      <= '0;
      projectile_r <= '0;
      pickup_r     <= '0;
      effect_r     <= '0;
    end else begin
      live_r       <= live_nxt;
      enemy_r      <= enemy_nxt;
      projectile_r <= projectile_nxt;
      pickup_r     <= pickup_nxt;
      effect_r     <= effect_nxt;
    end
  end

endmodule

// ===== hw/rtl/quota_pool_slot_allocator_unit.sv =====
// A request taken on start is read from the slot memory, then settled in S_EXEC; the result
// is registered out of S_EXEC, out_valid high for one cycle; the receiver cannot stall it.
// A new request is not taken while busy is high, that is while S_EXEC updates the list
// head and counters from the slot memory read.
// Reset (rst_n low, synchronous): list head 1, all counters 0, limits 12/16/16/8,
// every slot entry back to its power-on value at once; no clearing pass.
module quota_pool_slot_allocator_unit #(
  parameter int POOL_SLOTS = qpsa_pkg::POOL_SLOTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_mode,
  input  logic [qpsa_pkg::TYPE_W-1:0]         in_entity_type,
  input  logic [qpsa_pkg::SLOT_W-1:0]         in_slot,
  output logic                                out_valid,
  output logic [qpsa_pkg::STATUS_W-1:0]       out_status,
  output logic [qpsa_pkg::ID_W-1:0]           out_slot_id,
  output logic [qpsa_pkg::ROLE_W-1:0]         out_role_flags,
  output logic [qpsa_pkg::TOTAL_W-1:0]        out_live_total,
  input  logic                                cfg_we,
  input  logic [qpsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qpsa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = $clog2(POOL_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  logic [qpsa_pkg::LINK_W-1:0] head_r, head_nxt;
  logic                        req_mode_r;
  logic [qpsa_pkg::TYPE_W-1:0] req_type_r;
  logic [qpsa_pkg::SLOT_W-1:0] req_slot_r;

  logic                                 out_valid_r;
  qpsa_pkg::status_t                    out_status_r, status_nxt;
  logic [qpsa_pkg::ID_W-1:0]            out_slot_id_r;
  logic [qpsa_pkg::ROLE_W-1:0]          out_role_r, role_nxt;
  logic [qpsa_pkg::TOTAL_W-1:0]         out_total_r;
  logic [qpsa_pkg::LINK_W-1:0]          id_nxt;

  logic                  accept;
  logic                  head_empty, in_slot_ok, req_slot_ok;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  qpsa_pkg::slot_entry_t rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  qpsa_pkg::slot_entry_t wr_data;

  logic [qpsa_pkg::CAT_W-1:0] req_cat;
  logic                       quota_full;
  qpsa_pkg::cnt_upd_t         upd;
  logic [qpsa_pkg::CNT_W-1:0] live_nxt;

  assign busy   = (state_r == S_EXEC);
  assign accept = start && !busy;

  assign head_empty  = head_r >= qpsa_pkg::LINK_W'(POOL_SLOTS);
  assign in_slot_ok  = (in_slot != '0) && (in_slot < qpsa_pkg::SLOT_W'(POOL_SLOTS));
  assign req_slot_ok = (req_slot_r != '0) && (req_slot_r < qpsa_pkg::SLOT_W'(POOL_SLOTS));

  // read the list head for a spawn, the named slot for a free
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_r[AW-1:0];
    if (accept) begin
      if (in_mode == qpsa_pkg::MODE_FREE) begin
        rd_addr = in_slot[AW-1:0];
        rd_en   = in_slot_ok;
      end else begin
        rd_en   = !head_empty;
      end
    end
  end

  assign req_cat = req_type_r[qpsa_pkg::TYPE_W-1:qpsa_pkg::TYPE_W-qpsa_pkg::CAT_W];

  qpsa_slot_mem #(
    .POOL_SLOTS (POOL_SLOTS),
    .AW         (AW)
  ) u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  qpsa_quota u_quota (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .chk_cat    (req_cat),
    .quota_full (quota_full),
    .upd        (upd),
    .live_nxt   (live_nxt)
  );

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    status_nxt = qpsa_pkg::ST_OK;
    id_nxt     = '0;
    role_nxt   = '0;
    wr_en      = 1'b0;
    wr_addr    = head_r[AW-1:0];
    wr_data    = '0;
    upd        = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (req_mode_r == qpsa_pkg::MODE_SPAWN) begin
          if (quota_full) begin
            status_nxt = qpsa_pkg::ST_QUOTA_FULL;
          end else if (head_empty) begin
            status_nxt = qpsa_pkg::ST_POOL_EMPTY;
          end else begin
            // pop: head advances to its link, slot goes live
            id_nxt       = head_r;
            head_nxt     = rd_data.link;
            wr_en        = 1'b1;
            wr_data.link = '0;
            wr_data.live = 1'b1;
            wr_data.cat  = req_cat;
            upd.inc      = 1'b1;
            upd.cat      = req_cat;
            role_nxt     = qpsa_pkg::role_of(req_cat);
          end
        end else begin
          wr_addr = req_slot_r[AW-1:0];
          if (!req_slot_ok) begin
            status_nxt = qpsa_pkg::ST_BAD_SLOT;
          end else if (!rd_data.live) begin
            status_nxt = qpsa_pkg::ST_NOT_LIVE;
          end else begin
            // push: freed slot becomes the new head
            id_nxt       = req_slot_r[qpsa_pkg::LINK_W-1:0];
            head_nxt     = req_slot_r[qpsa_pkg::LINK_W-1:0];
            wr_en        = 1'b1;
            wr_data.link = head_r;
            upd.dec      = 1'b1;
            upd.cat      = rd_data.cat;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= qpsa_pkg::LINK_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode_r <= in_mode;
      req_type_r <= in_entity_type;
      req_slot_r <= in_slot;
    end
    if (busy) begin
      out_status_r  <= status_nxt;
      out_slot_id_r <= id_nxt[qpsa_pkg::ID_W-1:0];
      out_role_r    <= role_nxt;
      out_total_r   <= live_nxt[qpsa_pkg::TOTAL_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_id    = out_slot_id_r;
  assign out_role_flags = out_role_r;
  assign out_live_total = out_total_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS = qpsa_pkg::POOL_SLOTS_DEFAULT;

  typedef struct {
    qpsa_pkg::status_t                  status;
    logic [qpsa_pkg::ID_W-1:0]          slot_id;
    logic [qpsa_pkg::ROLE_W-1:0]        role;
    logic [qpsa_pkg::TOTAL_W-1:0]       total;
  } alloc_result_t;

  typedef enum logic {REQ_FIXED, REQ_FREE_LIVE} req_kind_t;

  typedef struct {
    req_kind_t                   kind;
    logic                        mode;
    logic [qpsa_pkg::TYPE_W-1:0] etype;
    logic [qpsa_pkg::SLOT_W-1:0] slot;
  } request_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              in_mode = qpsa_pkg::MODE_SPAWN;
  logic [qpsa_pkg::TYPE_W-1:0]       in_entity_type = '0;
  logic [qpsa_pkg::SLOT_W-1:0]       in_slot = '0;
  logic                              cfg_we = 1'b0;
  logic [qpsa_pkg::CFG_IDX_W-1:0]    cfg_index = qpsa_pkg::CFG_ENEMY_LIMIT;
  logic [qpsa_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
  logic                              busy;
  logic                              out_valid;
  logic [qpsa_pkg::STATUS_W-1:0]     out_status;
  logic [qpsa_pkg::ID_W-1:0]         out_slot_id;
  logic [qpsa_pkg::ROLE_W-1:0]       out_role_flags;
  logic [qpsa_pkg::TOTAL_W-1:0]      out_live_total;

  quota_pool_slot_allocator_unit #(.POOL_SLOTS(SLOTS)) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_entity_type (in_entity_type),
    .in_slot        (in_slot),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot_id    (out_slot_id),
    .out_role_flags (out_role_flags),
    .out_live_total (out_live_total),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pool state as the allocator should hold it
  logic [qpsa_pkg::LINK_W-1:0]  link_mem [SLOTS];
  logic [qpsa_pkg::LINK_W-1:0]  free_head;
  logic                         slot_in_use [SLOTS];
  logic [qpsa_pkg::CAT_W-1:0]   slot_cat [SLOTS];
  logic [qpsa_pkg::CNT_W-1:0]   live_cnt;
  logic [qpsa_pkg::CNT_W-1:0]   quota_cnt [4];
  logic [qpsa_pkg::LIMIT_W-1:0] quota_limit [4];

  request_t      pending_requests [$];
  alloc_result_t expected_allocs [$];
  request_t      drv_req;
  alloc_result_t mon_exp;
  int            send_idle_pct = 0;
  int            mismatch_count = 0;

  task automatic reset_pool_model();
    for (int i = 0; i < SLOTS; i++) begin
      link_mem[i]    = (i == 0) ? '0 : ((i == SLOTS - 1) ? qpsa_pkg::LINK_END :
                                        qpsa_pkg::LINK_W'(i + 1));
      slot_in_use[i] = 1'b0;
      slot_cat[i]    = '0;
    end
    free_head = qpsa_pkg::LINK_W'(1);
    live_cnt  = '0;
    for (int q = 0; q < 4; q++) quota_cnt[q] = '0;
    quota_limit[qpsa_pkg::CFG_ENEMY_LIMIT]      = qpsa_pkg::ENEMY_LIMIT_RST;
    quota_limit[qpsa_pkg::CFG_PROJECTILE_LIMIT] = qpsa_pkg::PROJECTILE_LIMIT_RST;
    quota_limit[qpsa_pkg::CFG_PICKUP_LIMIT]     = qpsa_pkg::PICKUP_LIMIT_RST;
    quota_limit[qpsa_pkg::CFG_EFFECT_LIMIT]     = qpsa_pkg::EFFECT_LIMIT_RST;
  endtask

  // work out the result of one request and advance the pool state
  task automatic predict_alloc(input logic mode, input logic [qpsa_pkg::TYPE_W-1:0] etype,
                               input logic [qpsa_pkg::SLOT_W-1:0] slot);
    alloc_result_t              r;
    logic [qpsa_pkg::CAT_W-1:0] cat;
    logic                       limited;
    logic                       quota_hit;
    int                         qi;
    int                         s;
    r.status  = qpsa_pkg::ST_OK;
    r.slot_id = '0;
    r.role    = '0;
    if (mode == qpsa_pkg::MODE_SPAWN) begin
      cat       = etype[7:4];
      limited   = (cat >= qpsa_pkg::CAT_ENEMY) && (cat <= qpsa_pkg::CAT_EFFECT);
      qi        = int'(cat) - int'(qpsa_pkg::CAT_ENEMY);
      quota_hit = 1'b0;
      if (limited) quota_hit = !(quota_cnt[qi] < quota_limit[qi]);
      if (quota_hit) begin
        r.status = qpsa_pkg::ST_QUOTA_FULL;
      end else if (free_head >= SLOTS) begin
        r.status = qpsa_pkg::ST_POOL_EMPTY;
      end else begin
        s              = int'(free_head);
        free_head      = link_mem[s];
        link_mem[s]    = '0;
        slot_in_use[s] = 1'b1;
        slot_cat[s]    = cat;
        if (live_cnt < qpsa_pkg::CNT_MAX) live_cnt++;
        if (limited && quota_cnt[qi] < qpsa_pkg::CNT_MAX) quota_cnt[qi]++;
        r.slot_id = s[qpsa_pkg::ID_W-1:0];
        case (cat)
          qpsa_pkg::CAT_FRIEND:     r.role = qpsa_pkg::FLAG_SOLID | qpsa_pkg::FLAG_FRIENDLY;
          qpsa_pkg::CAT_ENEMY:      r.role = qpsa_pkg::FLAG_SOLID | qpsa_pkg::FLAG_ENEMY;
          qpsa_pkg::CAT_PROJECTILE: r.role = qpsa_pkg::FLAG_SOLID;
          qpsa_pkg::CAT_PICKUP:     r.role = qpsa_pkg::FLAG_PICKUP;
          default:                  r.role = '0;
        endcase
      end
    end else begin
      if (slot == 0 || slot >= SLOTS) begin
        r.status = qpsa_pkg::ST_BAD_SLOT;
      end else if (!slot_in_use[slot]) begin
        r.status = qpsa_pkg::ST_NOT_LIVE;
      end else begin
        cat     = slot_cat[slot];
        limited = (cat >= qpsa_pkg::CAT_ENEMY) && (cat <= qpsa_pkg::CAT_EFFECT);
        qi      = int'(cat) - int'(qpsa_pkg::CAT_ENEMY);
        if (limited && quota_cnt[qi] > 0) quota_cnt[qi]--;
        slot_in_use[slot] = 1'b0;
        slot_cat[slot]    = '0;
        link_mem[slot]    = free_head;
        free_head         = slot[qpsa_pkg::LINK_W-1:0];
        if (live_cnt > 0) live_cnt--;
        r.slot_id = slot[qpsa_pkg::ID_W-1:0];
      end
    end
    r.total = live_cnt[qpsa_pkg::TOTAL_W-1:0];
    expected_allocs.push_back(r);
  endtask

  function automatic logic [qpsa_pkg::SLOT_W-1:0] pick_live_slot();
    logic [qpsa_pkg::SLOT_W-1:0] cands [$];
    for (int i = 1; i < SLOTS; i++)
      if (slot_in_use[i]) cands.push_back(qpsa_pkg::SLOT_W'(i));
    if (cands.size() == 0) return qpsa_pkg::SLOT_W'($urandom_range(255));
    return cands[$urandom_range(cands.size() - 1)];
  endfunction

  // driver: predict on each accepted transfer, then present the next request
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_alloc(in_mode, in_entity_type, in_slot);
      if (!start || !busy) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_req = pending_requests.pop_front();
          if (drv_req.kind == REQ_FREE_LIVE) drv_req.slot = pick_live_slot();
          start          <= 1'b1;
          in_mode        <= drv_req.mode;
          in_entity_type <= drv_req.etype;
          in_slot        <= drv_req.slot;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result must match the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_allocs.size() == 0) begin
        $error("unexpected transfer: status %0d slot_id %0d", out_status, out_slot_id);
        mismatch_count++;
      end else begin
        mon_exp = expected_allocs.pop_front();
        if (out_status !== mon_exp.status) begin
          $error("status: expected %0d, got %0d", mon_exp.status, out_status);
          mismatch_count++;
        end
        if (out_slot_id !== mon_exp.slot_id) begin
          $error("slot_id: expected %0d, got %0d", mon_exp.slot_id, out_slot_id);
          mismatch_count++;
        end
        if (out_role_flags !== mon_exp.role) begin
          $error("role_flags: expected %0h, got %0h", mon_exp.role, out_role_flags);
          mismatch_count++;
        end
        if (out_live_total !== mon_exp.total) begin
          $error("live_total: expected %0d, got %0d", mon_exp.total, out_live_total);
          mismatch_count++;
        end
      end
    end
  end

  task automatic push_fixed(input logic mode, input logic [qpsa_pkg::TYPE_W-1:0] etype,
                            input logic [qpsa_pkg::SLOT_W-1:0] slot);
    request_t r;
    r.kind  = REQ_FIXED;
    r.mode  = mode;
    r.etype = etype;
    r.slot  = slot;
    pending_requests.push_back(r);
  endtask

  // settle at the falling edge so that no posedge update is still in flight
  task automatic wait_drained();
    @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_allocs.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_limit(input logic [qpsa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [qpsa_pkg::LIMIT_W-1:0] val);
    @(posedge clk);
    cfg_we           <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= val;
    quota_limit[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(input logic [qpsa_pkg::LIMIT_W-1:0] en,
                            input logic [qpsa_pkg::LIMIT_W-1:0] pr,
                            input logic [qpsa_pkg::LIMIT_W-1:0] pk,
                            input logic [qpsa_pkg::LIMIT_W-1:0] ef);
    write_limit(qpsa_pkg::CFG_ENEMY_LIMIT, en);
    write_limit(qpsa_pkg::CFG_PROJECTILE_LIMIT, pr);
    write_limit(qpsa_pkg::CFG_PICKUP_LIMIT, pk);
    write_limit(qpsa_pkg::CFG_EFFECT_LIMIT, ef);
  endtask

  // mostly categories 0 to 5, now and then any type byte
  task automatic push_random(input int n, input int spawn_pct, input int live_free_pct);
    request_t                   r;
    int                         pick;
    logic [qpsa_pkg::CAT_W-1:0] cat;
    for (int i = 0; i < n; i++) begin
      pick    = $urandom_range(99);
      r.kind  = REQ_FIXED;
      r.etype = qpsa_pkg::TYPE_W'($urandom_range(255));
      r.slot  = qpsa_pkg::SLOT_W'($urandom_range(255));
      if (pick < spawn_pct) begin
        r.mode = qpsa_pkg::MODE_SPAWN;
        if ($urandom_range(3) != 0) begin
          cat     = qpsa_pkg::CAT_W'($urandom_range(5));
          r.etype = {cat, r.etype[3:0]};
        end
      end else begin
        r.mode = qpsa_pkg::MODE_FREE;
        if (pick < spawn_pct + live_free_pct) r.kind = REQ_FREE_LIVE;
        else if ($urandom_range(1) == 0) r.slot = qpsa_pkg::SLOT_W'($urandom_range(SLOTS - 1));
      end
      pending_requests.push_back(r);
    end
  endtask

  task automatic run_random(input int n, input int spawn_pct, input int live_free_pct,
                            input int idle_pct);
    send_idle_pct = idle_pct;
    push_random(n / 2, spawn_pct, live_free_pct);
    // hold the sender until the pool has answered everything
    wait_drained();
    push_random(n - n / 2, spawn_pct, live_free_pct);
    wait_drained();
  endtask

  initial begin
    reset_pool_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 0;
    push_fixed(qpsa_pkg::MODE_SPAWN, 8'h00, 8'h00);
    push_fixed(qpsa_pkg::MODE_SPAWN, 8'h1F, 8'hFF);
    push_fixed(qpsa_pkg::MODE_SPAWN, 8'h2A, 8'h00);
    push_fixed(qpsa_pkg::MODE_SPAWN, 8'h3B, 8'h00);
    push_fixed(qpsa_pkg::MODE_SPAWN, 8'h4C, 8'h00);
    push_fixed(qpsa_pkg::MODE_SPAWN, 8'h5D, 8'h00);
    push_fixed(qpsa_pkg::MODE_SPAWN, 8'hF0, 8'h00);
    push_fixed(qpsa_pkg::MODE_SPAWN, 8'hFF, 8'h00);
    push_fixed(qpsa_pkg::MODE_FREE, 8'h00, 8'd0);
    push_fixed(qpsa_pkg::MODE_FREE, 8'h00, 8'd64);
    push_fixed(qpsa_pkg::MODE_FREE, 8'hFF, 8'd255);
    push_fixed(qpsa_pkg::MODE_FREE, 8'h00, 8'd128);
    push_fixed(qpsa_pkg::MODE_FREE, 8'h00, 8'd127);
    push_fixed(qpsa_pkg::MODE_FREE, 8'h00, 8'd63);
    push_fixed(qpsa_pkg::MODE_FREE, 8'h00, 8'd3);
    push_fixed(qpsa_pkg::MODE_SPAWN, 8'h80, 8'h00);
    push_fixed(qpsa_pkg::MODE_FREE, 8'h00, 8'd3);
    push_fixed(qpsa_pkg::MODE_FREE, 8'h00, 8'd3);
    push_fixed(qpsa_pkg::MODE_FREE, 8'h00, 8'd6);
    push_fixed(qpsa_pkg::MODE_SPAWN, 8'h2F, 8'h00);
    wait_drained();

    write_limit(qpsa_pkg::CFG_EFFECT_LIMIT, 7'd0);
    push_fixed(qpsa_pkg::MODE_SPAWN, 8'h50, 8'h00);
    push_fixed(qpsa_pkg::MODE_SPAWN, 8'h5F, 8'h00);
    push_fixed(qpsa_pkg::MODE_SPAWN, 8'h00, 8'h00);
    wait_drained();

    // tight quotas with a spawn-heavy mix: quota ahead of pool
    set_limits(7'd1, 7'd2, 7'd0, 7'd3);
    run_random(200, 70, 20, 0);

    set_limits(7'd64, 7'd64, 7'd64, 7'd64);
    run_random(200, 55, 30, 77);

    set_limits(7'd127, 7'd127, 7'd127, 7'd127);
    run_random(200, 50, 35, 26);

    set_limits(qpsa_pkg::LIMIT_W'($urandom_range(127)), qpsa_pkg::LIMIT_W'($urandom_range(8)),
               qpsa_pkg::LIMIT_W'($urandom_range(64)), qpsa_pkg::LIMIT_W'($urandom_range(3)));
    run_random(200, 45, 35, 0);

    repeat (10) @(posedge clk);
    if (expected_allocs.size() != 0) begin
      $error("%0d results never arrived", expected_allocs.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
